// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers for the block, clocked on clk and disabled
// while rst_n is low. They compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define NAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NAT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define NAT_ASSERT(lbl, prop, msg)
`define NAT_IMPLY(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/nat_pkg.sv =====
// ----------------------------------------------------------------------------
// Network address table package
// Field widths, flag layout, request codes and sequencer states used by
// the address table.
// ----------------------------------------------------------------------------
`default_nettype none

package nat_pkg;

  localparam int ENTRIES_DEF = 32;

  localparam int REQ_W   = 3;
  localparam int USER_W  = 4;
  localparam int SHORT_W = 16;
  localparam int LONG_W  = 64;
  localparam int SLOT_W  = 5;
  localparam int FLAG_W  = 6;

  localparam int FLAG_USED  = 4;
  localparam int FLAG_DIRTY = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_UPDATE       = 3'd0,
    REQ_LOOKUP_SHORT = 3'd1,
    REQ_LOOKUP_LONG  = 3'd2,
    REQ_GET          = 3'd3,
    REQ_ADD_REF      = 3'd4,
    REQ_RELEASE      = 3'd5
  } nat_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SLOT_RD,
    ST_SLOT_CHK
  } nat_state_t;

endpackage

`default_nettype wire

// ===== hdl/network_address_table_top.sv =====
// ----------------------------------------------------------------------------
// Network address table
// Maps short network addresses to extended addresses with per-entry user
// bits, a used mark and a dirty mark.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low; busy then stays
// high until the request has finished. Update and both lookups walk the table
// one entry per cycle through the single read port of the address RAM, so
// they finish after the last entry or early on a hit. Get, add-reference and
// release read one entry. The result beat is shown for exactly one cycle with
// out_valid high and cannot be held off, so it must be captured when it
// appears. The used marks are cleared at reset, which empties the table at
// once.
`default_nettype none

`include "assert_macros.svh"

module network_address_table_top #(
  parameter int ENTRIES = nat_pkg::ENTRIES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [nat_pkg::REQ_W-1:0]   in_req_type,
  input  wire logic [nat_pkg::USER_W-1:0]  in_user_bits,
  input  wire logic [nat_pkg::SHORT_W-1:0] in_short_addr,
  input  wire logic [nat_pkg::LONG_W-1:0]  in_long_addr,
  input  wire logic [nat_pkg::SLOT_W-1:0]  in_slot,
  output logic                             out_valid,
  output logic                             out_ok,
  output logic      [nat_pkg::SLOT_W-1:0]  out_found_slot,
  output logic      [nat_pkg::SHORT_W-1:0] out_found_short,
  output logic      [nat_pkg::LONG_W-1:0]  out_found_long,
  output logic                             out_table_full
);

  import nat_pkg::*;

  localparam int IW    = $clog2(ENTRIES);
  localparam int CW    = $clog2(ENTRIES + 1);
  localparam int SW    = (IW > SLOT_W) ? IW : SLOT_W;
  localparam int RAM_W = SHORT_W + LONG_W;

  nat_state_t state_r, state_nxt;

  logic [REQ_W-1:0]   req_r, req_nxt;
  logic [USER_W-1:0]  user_r, user_nxt;
  logic [SHORT_W-1:0] sa_r, sa_nxt;
  logic [LONG_W-1:0]  la_r, la_nxt;
  logic               slot_go_r, slot_go_nxt;

  logic [IW:0]   scan_idx_r, scan_idx_nxt;
  logic          cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic          sh_hit_r, sh_hit_nxt;
  logic [IW-1:0] sh_idx_r, sh_idx_nxt;
  logic          free_hit_r, free_hit_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;

  logic [FLAG_W-1:0] flags_r [ENTRIES];
  logic [CW-1:0]     used_cnt_r, used_cnt_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_ok_r, out_ok_nxt;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic [SHORT_W-1:0] out_short_r, out_short_nxt;
  logic [LONG_W-1:0]  out_long_r, out_long_nxt;
  logic               out_full_r, out_full_nxt;

  logic [SW:0]         slot_ext;
  logic                slot_ok;
  logic [IW-1:0]       ram_raddr;
  logic [RAM_W-1:0]    ram_rdata;
  logic                ram_we;
  logic [FLAG_W-1:0]   fl_rd;
  logic                cur_used;
  logic [USER_W-1:0]   cur_user;
  logic [SHORT_W-1:0]  rd_short;
  logic [LONG_W-1:0]   rd_long;
  logic                long_eq, short_eq, user_eq;
  logic                scan_issue, scan_last, scan_done;
  logic                commit, res_ok, flag_we, cnt_inc, full_after;
  logic [IW-1:0]       res_idx;
  logic [SW-1:0]       res_idx_w;
  logic [SHORT_W-1:0]  res_short;
  logic [LONG_W-1:0]   res_long;
  logic [FLAG_W-1:0]   flag_wdata;

  assign slot_ext = (SW + 1)'(in_slot);
  assign slot_ok  = slot_ext < (SW + 1)'(ENTRIES);

  assign fl_rd    = flags_r[cmp_idx_r];
  assign cur_used = fl_rd[FLAG_USED];
  assign cur_user = fl_rd[USER_W-1:0];
  assign rd_short = ram_rdata[LONG_W +: SHORT_W];
  assign rd_long  = ram_rdata[LONG_W-1:0];
  assign long_eq  = rd_long == la_r;
  assign short_eq = rd_short == sa_r;
  assign user_eq  = cur_user == user_r;

  assign scan_issue = (state_r == ST_SCAN) && (scan_idx_r < (IW + 1)'(ENTRIES));
  assign scan_last  = cmp_idx_r == IW'(ENTRIES - 1);
  assign ram_raddr  = (state_r == ST_SCAN) ? scan_idx_r[IW-1:0] : cmp_idx_r;

  nat_ram #(
    .WIDTH(RAM_W),
    .DEPTH(ENTRIES)
  ) u_addr_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(res_idx),
    .wdata({sa_r, la_r}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_req_type inside {REQ_UPDATE, REQ_LOOKUP_SHORT, REQ_LOOKUP_LONG}) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_SLOT_RD;
          end
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SLOT_RD:  state_nxt = ST_SLOT_CHK;
      ST_SLOT_CHK: state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    req_nxt      = req_r;
    user_nxt     = user_r;
    sa_nxt       = sa_r;
    la_nxt       = la_r;
    slot_go_nxt  = slot_go_r;
    scan_idx_nxt = scan_idx_r;
    cmp_vld_nxt  = cmp_vld_r;
    cmp_idx_nxt  = cmp_idx_r;
    sh_hit_nxt   = sh_hit_r;
    sh_idx_nxt   = sh_idx_r;
    free_hit_nxt = free_hit_r;
    free_idx_nxt = free_idx_r;
    commit       = 1'b0;
    res_ok       = 1'b0;
    res_idx      = cmp_idx_r;
    res_short    = rd_short;
    res_long     = rd_long;
    ram_we       = 1'b0;
    flag_we      = 1'b0;
    flag_wdata   = fl_rd;
    cnt_inc      = 1'b0;
    scan_done    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt      = in_req_type;
          user_nxt     = in_user_bits;
          sa_nxt       = in_short_addr;
          la_nxt       = in_long_addr;
          slot_go_nxt  = slot_ok && (in_user_bits != '0);
          scan_idx_nxt = '0;
          cmp_vld_nxt  = 1'b0;
          cmp_idx_nxt  = slot_ext[IW-1:0];
          sh_hit_nxt   = 1'b0;
          free_hit_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        if (scan_issue) begin
          scan_idx_nxt = scan_idx_r + (IW + 1)'(1);
        end
        cmp_vld_nxt = scan_issue;
        cmp_idx_nxt = scan_idx_r[IW-1:0];
        if (cmp_vld_r) begin
          case (req_r)
            REQ_UPDATE: begin
              if (cur_used && long_eq) begin
                commit = 1'b1;
                res_ok = 1'b1;
              end else begin
                if (cur_used && short_eq && !sh_hit_r) begin
                  sh_hit_nxt = 1'b1;
                  sh_idx_nxt = cmp_idx_r;
                end
                if (!cur_used && !free_hit_r) begin
                  free_hit_nxt = 1'b1;
                  free_idx_nxt = cmp_idx_r;
                end
                if (scan_last) begin
                  commit = 1'b1;
                  if (sh_hit_r || (cur_used && short_eq)) begin
                    res_ok  = 1'b1;
                    res_idx = sh_hit_r ? sh_idx_r : cmp_idx_r;
                  end else if (free_hit_r || !cur_used) begin
                    res_ok  = 1'b1;
                    res_idx = free_hit_r ? free_idx_r : cmp_idx_r;
                    cnt_inc = 1'b1;
                  end
                end
              end
              if (res_ok) begin
                ram_we     = 1'b1;
                flag_we    = 1'b1;
                flag_wdata = {1'b1, 1'b1, user_r};
                res_short  = sa_r;
                res_long   = la_r;
              end
            end
            REQ_LOOKUP_SHORT: begin
              if (cur_used && short_eq) begin
                commit = 1'b1;
                res_ok = 1'b1;
              end else if (scan_last) begin
                commit = 1'b1;
              end
            end
            REQ_LOOKUP_LONG: begin
              if (cur_used && long_eq && user_eq) begin
                commit = 1'b1;
                res_ok = 1'b1;
              end else if (scan_last) begin
                commit = 1'b1;
              end
            end
            default: commit = 1'b1;
          endcase
        end
        scan_done = commit;
      end
      ST_SLOT_CHK: begin
        commit    = 1'b1;
        res_short = cur_used ? rd_short : '0;
        res_long  = cur_used ? rd_long : '0;
        case (req_r)
          REQ_GET: res_ok = slot_go_r && cur_used && user_eq;
          REQ_ADD_REF: begin
            if (slot_go_r && !user_eq) begin
              res_ok     = 1'b1;
              flag_we    = 1'b1;
              flag_wdata = {1'b1, cur_used, cur_user | user_r};
            end
          end
          REQ_RELEASE: begin
            if (slot_go_r) begin
              res_ok     = 1'b1;
              flag_we    = 1'b1;
              flag_wdata = {1'b1, cur_used, cur_user & ~user_r};
            end
          end
          default: res_ok = 1'b0;
        endcase
      end
      default: begin
      end
    endcase
  end

  assign used_cnt_nxt = used_cnt_r + CW'(cnt_inc);
  assign full_after   = used_cnt_nxt == CW'(ENTRIES);
  assign res_idx_w    = SW'(res_idx);

  always_comb begin
    out_valid_nxt = 1'b0;
    out_ok_nxt    = out_ok_r;
    out_slot_nxt  = out_slot_r;
    out_short_nxt = out_short_r;
    out_long_nxt  = out_long_r;
    out_full_nxt  = out_full_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
      out_ok_nxt    = res_ok;
      out_slot_nxt  = res_ok ? res_idx_w[SLOT_W-1:0] : '0;
      out_short_nxt = res_ok ? res_short : '0;
      out_long_nxt  = res_ok ? res_long : '0;
      out_full_nxt  = full_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      used_cnt_r  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        flags_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      used_cnt_r  <= used_cnt_nxt;
      if (flag_we) begin
        flags_r[res_idx] <= flag_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    user_r      <= user_nxt;
    sa_r        <= sa_nxt;
    la_r        <= la_nxt;
    slot_go_r   <= slot_go_nxt;
    scan_idx_r  <= scan_idx_nxt;
    cmp_vld_r   <= cmp_vld_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    sh_hit_r    <= sh_hit_nxt;
    sh_idx_r    <= sh_idx_nxt;
    free_hit_r  <= free_hit_nxt;
    free_idx_r  <= free_idx_nxt;
    out_ok_r    <= out_ok_nxt;
    out_slot_r  <= out_slot_nxt;
    out_short_r <= out_short_nxt;
    out_long_r  <= out_long_nxt;
    out_full_r  <= out_full_nxt;
  end

  assign busy            = state_r != ST_IDLE;
  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_found_slot  = out_slot_r;
  assign out_found_short = out_short_r;
  assign out_found_long  = out_long_r;
  assign out_table_full  = out_full_r;

  `NAT_ASSERT(a_accept_goes_busy, (start && !busy) |=> busy, "accepted beat did not raise busy")
  `NAT_ASSERT(a_strobe_single, out_valid |=> !out_valid, "result strobe held for two cycles")
  `NAT_IMPLY(a_count_range, 1'b1, used_cnt_r <= CW'(ENTRIES), "used count beyond table size")
  `NAT_IMPLY(a_full_matches, out_valid, out_table_full == (used_cnt_r == CW'(ENTRIES)), "full flag disagrees with used count")

endmodule

`default_nettype wire

// ===== hdl/nat_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module nat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire
